/* rtl/core/lir_pkg.sv */
`timescale 1ns / 1ps
// lir_pkg: shared types and constants of the linear interpolation resampler.
// Used by lir_cfg, lir_blend and linear_interp_resampler.
package lir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = SAMPLE_W + 1;
    localparam int RATE_W   = 18;
    localparam int PHASE_W  = RATE_W + 1;
    localparam int CH_W     = 2;
    localparam int NUM_W    = 36;
    localparam int REM_W    = NUM_W - 1;
    localparam int DEN_W    = RATE_W + 1;
    localparam int QUO_W    = SUM_W;
    localparam int QCNT_W   = $clog2(QUO_W);

    localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(16000);
    localparam logic [CH_W-1:0]   CH_RST   = CH_W'(1);

    localparam logic signed [SAMPLE_W+1:0] SAT_HI = 18'sd32767;
    localparam logic signed [SAMPLE_W+1:0] SAT_LO = -18'sd32768;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        REG_IN_RATE  = 2'd0,
        REG_OUT_RATE = 2'd1,
        REG_IN_CH    = 2'd2,
        REG_OUT_CH   = 2'd3
    } reg_idx_t;

    // effective settings after zero, ratio and channel clamping
    typedef struct packed {
        logic [RATE_W-1:0] ir;
        logic [RATE_W-1:0] eo;
        logic              two_in;
        logic              two_out;
    } cfg_eff_t;

    // one blend: (s0*w0 + s1*w1) / (eo * (half ? 2 : 1))
    typedef struct packed {
        logic signed [SUM_W-1:0] s0;
        logic signed [SUM_W-1:0] s1;
        logic [RATE_W-1:0]       w0;
        logic [RATE_W-1:0]       w1;
        logic [RATE_W-1:0]       eo;
        logic                    half;
    } blend_req_t;

endpackage

/* rtl/core/lir_cfg.sv */
`timescale 1ns / 1ps
// lir_cfg: configuration registers and derived effective rates and channel flags.
// Depends on lir_pkg.
module lir_cfg
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS = 2,
    parameter int MAX_UPSAMPLE = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [RATE_W-1:0] cfg_data,
    output cfg_eff_t          eff
);

    localparam int UP_W  = $clog2(MAX_UPSAMPLE + 1);
    localparam int LIM_W = RATE_W + UP_W;

    logic [RATE_W-1:0] in_rate_reg;
    logic [RATE_W-1:0] out_rate_reg;
    logic [CH_W-1:0]   in_ch_reg;
    logic [CH_W-1:0]   out_ch_reg;
    cfg_eff_t          eff_reg;
    cfg_eff_t          eff_next;

    logic [RATE_W-1:0] ir_eff;
    logic [RATE_W-1:0] eo_raw;
    logic [LIM_W-1:0]  lim;

    assign cfg_ready = 1'b1;
    assign eff       = eff_reg;

    always_comb
    begin
        ir_eff = (in_rate_reg == '0) ? RATE_W'(1) : in_rate_reg;
        eo_raw = (out_rate_reg == '0) ? RATE_W'(1) : out_rate_reg;
        lim    = LIM_W'(ir_eff) * LIM_W'(MAX_UPSAMPLE);
        eff_next.ir      = ir_eff;
        eff_next.eo      = (LIM_W'(eo_raw) > lim) ? lim[RATE_W-1:0] : eo_raw;
        eff_next.two_in  = (MAX_CHANNELS >= 2) && (in_ch_reg >= CH_W'(2));
        eff_next.two_out = (MAX_CHANNELS >= 2) && (out_ch_reg >= CH_W'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rate_reg  <= RATE_RST;
            out_rate_reg <= RATE_RST;
            in_ch_reg    <= CH_RST;
            out_ch_reg   <= CH_RST;
            eff_reg.ir      <= RATE_RST;
            eff_reg.eo      <= RATE_RST;
            eff_reg.two_in  <= 1'b0;
            eff_reg.two_out <= 1'b0;
        end
        else
        begin
            eff_reg <= eff_next;
            if (cfg_valid)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_IN_RATE:  in_rate_reg  <= cfg_data;
                    REG_OUT_RATE: out_rate_reg <= cfg_data;
                    REG_IN_CH:    in_ch_reg    <= cfg_data[CH_W-1:0];
                    REG_OUT_CH:   out_ch_reg   <= cfg_data[CH_W-1:0];
                endcase
            end
        end
    end

endmodule

/* rtl/core/lir_blend.sv */
`timescale 1ns / 1ps
// lir_blend: shared multiply-accumulate and restoring divider, one step a cycle.
// Computes (s0*w0 + s1*w1) / den truncated toward zero, saturated. Depends on lir_pkg.
module lir_blend
    import lir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  blend_req_t req,
    output logic       done,
    output sample_t    result
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL0,
        B_MUL1,
        B_ABS,
        B_DIV,
        B_FIX
    } bstate_t;

    bstate_t                 state_reg;
    blend_req_t              req_reg;
    logic signed [NUM_W-1:0] acc_reg;
    logic                    neg_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [REM_W-1:0]        den_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [QCNT_W-1:0]       cnt_reg;
    logic                    done_reg;
    sample_t                 result_reg;

    logic signed [SUM_W-1:0]  mul_a;
    logic signed [DEN_W-1:0]  mul_b;
    logic signed [NUM_W-1:0]  prod;
    logic signed [NUM_W-1:0]  mag;
    logic [DEN_W-1:0]         den;
    logic                     fits;
    logic signed [QUO_W:0]    sq;
    sample_t                  sat;

    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        mul_a = (state_reg == B_MUL0) ? req_reg.s0 : req_reg.s1;
        mul_b = (state_reg == B_MUL0) ? $signed({1'b0, req_reg.w0})
                                      : $signed({1'b0, req_reg.w1});
        prod  = mul_a * mul_b;
        mag   = acc_reg[NUM_W-1] ? -acc_reg : acc_reg;
        den   = req_reg.half ? {req_reg.eo, 1'b0} : {1'b0, req_reg.eo};
        fits  = (rem_reg >= den_reg);
        sq    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        if (sq > SAT_HI)
            sat = SAT_HI[SAMPLE_W-1:0];
        else if (sq < SAT_LO)
            sat = SAT_LO[SAMPLE_W-1:0];
        else
            sat = sq[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        state_reg <= B_MUL0;
                    end
                end
                B_MUL0:
                begin
                    acc_reg   <= prod;
                    state_reg <= B_MUL1;
                end
                B_MUL1:
                begin
                    acc_reg   <= acc_reg + prod;
                    state_reg <= B_ABS;
                end
                B_ABS:
                begin
                    neg_reg   <= acc_reg[NUM_W-1];
                    rem_reg   <= mag[REM_W-1:0];
                    den_reg   <= {den, {(QUO_W-1){1'b0}}};
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    if (fits)
                        rem_reg <= rem_reg - den_reg;
                    quo_reg <= {quo_reg[QUO_W-2:0], fits};
                    den_reg <= den_reg >> 1;
                    cnt_reg <= cnt_reg + QCNT_W'(1);
                    if (cnt_reg == QCNT_W'(QUO_W - 1))
                        state_reg <= B_FIX;
                end
                B_FIX:
                begin
                    result_reg <= sat;
                    done_reg   <= 1'b1;
                    state_reg  <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == B_IDLE))
        else $error("blend started while busy");

    a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == B_FIX))
        else $error("blend done without final step");
`endif

endmodule

/* rtl/core/linear_interp_resampler.sv */
`timescale 1ns / 1ps
// Linear interpolation resampler: 16-bit frames in, frames at out_rate/in_rate out.
// Each output frame takes one blend, or two when both channels are blended; all blends
// run on the shared multiply/divide unit in lir_blend.
// Throughput: one item at a time; s_tready is high only between items.
// Reset: control and stream state clear, rates to 16000, channels to 1.
// Depends on lir_pkg, lir_cfg, lir_blend.
module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS = 2,
    parameter int MAX_UPSAMPLE = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // sample_first, sample_second
    input  logic              s_tlast,   // final_frame
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // result_first, result_second
    output logic              m_tlast,   // run_end
    output logic              m_tuser,   // stream_end
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);

    localparam int CAP   = 2 * MAX_UPSAMPLE;
    localparam int CNT_W = $clog2(CAP + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_BLEND0,
        S_BLEND1,
        S_COMMIT,
        S_FINISH
    } state_t;

    cfg_eff_t eff;

    state_t             state_reg;
    sample_t            cur0_reg;
    sample_t            cur1_reg;
    logic               fin_reg;
    sample_t            prev0_reg;
    sample_t            prev1_reg;
    logic               have_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] p_reg;
    logic               tail_reg;
    logic [CNT_W-1:0]   n_reg;
    sample_t            r0_reg;
    sample_t            r1_reg;
    sample_t            hold0_reg;
    sample_t            hold1_reg;
    logic               hold_valid_reg;
    logic               out_valid_reg;
    sample_t            out0_reg;
    sample_t            out1_reg;
    logic               out_last_reg;
    logic               out_end_reg;

    logic               accept;
    logic               out_free;
    logic               push;
    logic               more;
    logic               two_blend;
    logic               start;
    blend_req_t         req;
    logic               b_done;
    sample_t            b_result;
    sample_t            a0;
    sample_t            a1;
    logic signed [SUM_W-1:0] ea0;
    logic signed [SUM_W-1:0] ea1;
    logic signed [SUM_W-1:0] eb0;
    logic signed [SUM_W-1:0] eb1;
    logic [RATE_W-1:0]  w1;

    lir_cfg #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff)
    );

    lir_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .done   (b_done),
        .result (b_result)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out1_reg, out0_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    always_comb
    begin
        more      = (p_reg < PHASE_W'(eff.eo)) && (n_reg < CNT_W'(CAP));
        two_blend = eff.two_out && eff.two_in;
        push      = ((state_reg == S_COMMIT) || (state_reg == S_FINISH))
                 && hold_valid_reg && out_free;
        a0  = tail_reg ? cur0_reg : prev0_reg;
        a1  = tail_reg ? cur1_reg : prev1_reg;
        ea0 = {a0[SAMPLE_W-1], a0};
        ea1 = {a1[SAMPLE_W-1], a1};
        eb0 = {cur0_reg[SAMPLE_W-1], cur0_reg};
        eb1 = {cur1_reg[SAMPLE_W-1], cur1_reg};
        w1  = tail_reg ? '0 : p_reg[RATE_W-1:0];

        req.w0   = eff.eo - w1;
        req.w1   = w1;
        req.eo   = eff.eo;
        req.half = 1'b0;
        if (!eff.two_out)
        begin
            req.s0   = ea0 + (eff.two_in ? ea1 : '0);
            req.s1   = eb0 + (eff.two_in ? eb1 : '0);
            req.half = eff.two_in;
        end
        else if (state_reg == S_BLEND0)
        begin
            req.s0 = ea1;
            req.s1 = eb1;
        end
        else
        begin
            req.s0 = ea0;
            req.s1 = eb0;
        end

        start = ((state_reg == S_TEST) && more)
             || ((state_reg == S_BLEND0) && b_done && two_blend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            have_reg       <= 1'b0;
            phase_reg      <= '0;
            prev0_reg      <= '0;
            prev1_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            n_reg          <= '0;
            tail_reg       <= 1'b0;
            fin_reg        <= 1'b0;
            p_reg          <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !push)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur0_reg <= s_tdata[15:0];
                        cur1_reg <= s_tdata[31:16];
                        fin_reg  <= s_tlast;
                        n_reg    <= '0;
                        tail_reg <= !have_reg;
                        p_reg    <= have_reg ? phase_reg : '0;
                        state_reg <= (have_reg || s_tlast) ? S_TEST : S_FINISH;
                    end
                end
                S_TEST:
                begin
                    if (more)
                        state_reg <= S_BLEND0;
                    else if (!tail_reg)
                    begin
                        p_reg <= (p_reg >= PHASE_W'(eff.eo)) ? p_reg - PHASE_W'(eff.eo) : '0;
                        if (fin_reg)
                            tail_reg <= 1'b1;
                        else
                            state_reg <= S_FINISH;
                    end
                    else
                        state_reg <= S_FINISH;
                end
                S_BLEND0:
                begin
                    if (b_done)
                    begin
                        r0_reg <= b_result;
                        if (two_blend)
                            state_reg <= S_BLEND1;
                        else
                        begin
                            r1_reg    <= eff.two_out ? b_result : '0;
                            state_reg <= S_COMMIT;
                        end
                    end
                end
                S_BLEND1:
                begin
                    if (b_done)
                    begin
                        r1_reg    <= b_result;
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out0_reg      <= hold0_reg;
                            out1_reg      <= hold1_reg;
                            out_last_reg  <= 1'b0;
                            out_end_reg   <= 1'b0;
                        end
                        hold0_reg      <= r0_reg;
                        hold1_reg      <= r1_reg;
                        hold_valid_reg <= 1'b1;
                        n_reg          <= n_reg + CNT_W'(1);
                        p_reg          <= p_reg + PHASE_W'(eff.ir);
                        state_reg      <= S_TEST;
                    end
                end
                S_FINISH:
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out0_reg      <= hold0_reg;
                            out1_reg      <= hold1_reg;
                            out_last_reg  <= 1'b1;
                            out_end_reg   <= fin_reg;
                        end
                        hold_valid_reg <= 1'b0;
                        if (fin_reg)
                        begin
                            prev0_reg <= '0;
                            prev1_reg <= '0;
                            have_reg  <= 1'b0;
                            phase_reg <= '0;
                        end
                        else
                        begin
                            prev0_reg <= cur0_reg;
                            prev1_reg <= cur1_reg;
                            have_reg  <= 1'b1;
                            phase_reg <= p_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !hold_valid_reg)
        else $error("result left pending between items");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(CAP))
        else $error("result count past cap");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("stream end not on last result of run");

    a_start_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (p_reg < PHASE_W'(eff.eo)))
        else $error("blend started past phase limit");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for linear_interp_resampler: a hand-written table of frames and
// register writes, then random streams under several idle and stall mixes.
// Depends on lir_pkg and the resampler RTL; results are checked against a local predictor.
module testbench;
    import lir_pkg::*;

    localparam int UPSAMPLE_CAP  = 16;
    localparam int RESULT_CAP    = 2 * UPSAMPLE_CAP;
    localparam int SETTLE_CYCLES = 64;
    localparam int END_SETTLE    = 200;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int GROUP_ITEMS   = 40;
    localparam int PRINT_CAP     = 40;

    typedef struct packed {
        sample_t ch0;
        sample_t ch1;
        logic    run_end;
        logic    stream_end;
    } frame_out_t;

    typedef struct {
        bit                is_cfg;
        reg_idx_t          idx;
        logic [RATE_W-1:0] val;
        sample_t           a;
        sample_t           b;
        bit                fin;
        bit                known;
        sample_t           expv;
    } step_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              m_tlast;
    logic              m_tuser;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [RATE_W-1:0] cfg_data;

    // predictor copy of registers and stream state
    logic [RATE_W-1:0]  in_rate_q;
    logic [RATE_W-1:0]  out_rate_q;
    logic [CH_W-1:0]    in_ch_q;
    logic [CH_W-1:0]    out_ch_q;
    sample_t            held_ch0;
    sample_t            held_ch1;
    bit                 have_held;
    logic [PHASE_W-1:0] phase_q;

    frame_out_t pending_frames[$];
    step_row_t  dir_rows[$];
    frame_out_t step_last;
    int         step_results;

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_left;
    int error_count;
    int items_sent;
    int results_seen;
    int reg_writes;
    int streams_done;
    int cycle_count;

    linear_interp_resampler #(
        .MAX_CHANNELS(2),
        .MAX_UPSAMPLE(UPSAMPLE_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        error_count++;
    endtask

    // exact (s0*eo + (s1-s0)*p) / (div*eo), truncated toward zero, saturated
    function automatic sample_t interp_sample(longint s0, longint s1, longint div,
                                              longint p, longint eo);
        longint q;
        q = (s0 * eo + (s1 - s0) * p) / (div * eo);
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return sample_t'(q);
    endfunction

    function automatic frame_out_t mix_frame(sample_t a0, sample_t a1, sample_t b0,
                                             sample_t b1, longint p, longint eo,
                                             bit two_in, bit two_out);
        frame_out_t r;
        longint     s0;
        longint     s1;
        r = '0;
        if (!two_out)
        begin
            s0 = longint'(a0) + (two_in ? longint'(a1) : 0);
            s1 = longint'(b0) + (two_in ? longint'(b1) : 0);
            r.ch0 = interp_sample(s0, s1, two_in ? 2 : 1, p, eo);
        end
        else
        begin
            r.ch0 = interp_sample(a0, b0, 1, p, eo);
            r.ch1 = two_in ? interp_sample(a1, b1, 1, p, eo) : r.ch0;
        end
        return r;
    endfunction

    function automatic void predict_frame(sample_t c0, sample_t c1, bit fin);
        longint     ir;
        longint     eo;
        longint     p;
        bit         two_in;
        bit         two_out;
        frame_out_t batch[$];
        frame_out_t r;
        ir      = (in_rate_q == 0) ? 1 : longint'(in_rate_q);
        eo      = (out_rate_q == 0) ? 1 : longint'(out_rate_q);
        two_in  = (in_ch_q >= 2);
        two_out = (out_ch_q >= 2);
        if (eo > UPSAMPLE_CAP * ir)
            eo = UPSAMPLE_CAP * ir;
        p = phase_q;
        if (!have_held)
            p = 0;
        else
        begin
            while (p < eo && batch.size() < RESULT_CAP)
            begin
                batch.push_back(mix_frame(held_ch0, held_ch1, c0, c1, p, eo, two_in, two_out));
                p += ir;
            end
            p = (p >= eo) ? p - eo : 0;
        end
        if (fin)
        begin
            while (p < eo && batch.size() < RESULT_CAP)
            begin
                batch.push_back(mix_frame(c0, c1, c0, c1, 0, eo, two_in, two_out));
                p += ir;
            end
            held_ch0  = '0;
            held_ch1  = '0;
            have_held = 0;
            phase_q   = '0;
        end
        else
        begin
            held_ch0  = c0;
            held_ch1  = c1;
            have_held = 1;
            phase_q   = PHASE_W'(p);
        end
        step_results = batch.size();
        if (step_results > 0)
        begin
            r = batch[step_results - 1];
            r.run_end = 1'b1;
            r.stream_end = fin;
            batch[step_results - 1] = r;
            step_last = r;
        end
        foreach (batch[i])
            pending_frames.push_back(batch[i]);
    endfunction

    function automatic void add_frame(sample_t a, sample_t b, bit fin, bit known,
                                      sample_t expv);
        step_row_t row;
        row = '{0, REG_IN_RATE, '0, a, b, fin, known, expv};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(reg_idx_t idx, logic [RATE_W-1:0] val);
        step_row_t row;
        row = '{1, idx, val, '0, '0, 0, 0, '0};
        dir_rows.push_back(row);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 11))
            0: return 8000;
            1: return 11025;
            2: return 16000;
            3: return 22050;
            4: return 32000;
            5: return 44100;
            6: return 48000;
            7: return 96000;
            8: return 192000;
            9: return RATE_W'($urandom_range(1, 64));
            10: return RATE_W'($urandom);
            default: return '0;
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] pick_channels();
        if ($urandom_range(0, 9) == 0)
            return RATE_W'($urandom);
        return RATE_W'($urandom_range(1, 2));
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [RATE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_IN_RATE:  in_rate_q  = val;
            REG_OUT_RATE: out_rate_q = val;
            REG_IN_CH:    in_ch_q    = val[CH_W-1:0];
            REG_OUT_CH:   out_ch_q   = val[CH_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic send_frame(sample_t a, sample_t b, bit fin);
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        predict_frame(a, b, fin);
        items_sent++;
        if (fin)
            streams_done++;
    endtask

    task automatic wait_idle(int settle);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // output side: random stall, optional long hold-off, check each accepted item
    initial
    begin
        frame_out_t want;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_frames.size() == 0)
                    report_mismatch("unexpected result, result_first",
                                    $signed(m_tdata[15:0]), 0);
                else
                begin
                    want = pending_frames.pop_front();
                    if (m_tdata[15:0] !== want.ch0)
                        report_mismatch("result_first", $signed(m_tdata[15:0]), want.ch0);
                    if (m_tdata[31:16] !== want.ch1)
                        report_mismatch("result_second", $signed(m_tdata[31:16]), want.ch1);
                    if (m_tlast !== want.run_end)
                        report_mismatch("run_end", m_tlast, want.run_end);
                    if (m_tuser !== want.stream_end)
                        report_mismatch("stream_end", m_tuser, want.stream_end);
                end
                results_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("linear_interp_resampler regression: fail");
        $finish;
    end

    initial
    begin
        int tx_mix[4];
        int rx_mix[4];
        int grp_items;
        int len;
        bit prev_cfg;
        bit fin;
        tx_mix = '{0, 55, 0, 23};
        rx_mix = '{0, 0, 55, 23};
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_left   = 0;
        error_count = 0;
        items_sent  = 0;
        results_seen = 0;
        reg_writes  = 0;
        streams_done = 0;
        step_results = 0;
        step_last   = '0;
        in_rate_q   = RATE_RST;
        out_rate_q  = RATE_RST;
        in_ch_q     = CH_RST;
        out_ch_q    = CH_RST;
        held_ch0    = '0;
        held_ch1    = '0;
        have_held   = 0;
        phase_q     = '0;

        // reset settings, 1:1 mono: each output repeats the held frame
        add_frame(32767, -32768, 0, 0, 0);
        add_frame(-32768, 32767, 0, 1, 32767);
        add_frame(0, 0, 0, 1, -32768);
        add_frame(1234, 16'h5555, 1, 1, 1234);
        add_frame(100, 0, 1, 1, 100);           // lone final frame
        // stereo in and out
        add_cfg(REG_IN_CH, 2);
        add_cfg(REG_OUT_CH, 2);
        add_frame(-32768, 32767, 0, 0, 0);
        add_frame(32767, -32768, 0, 1, -32768);
        add_frame(16'h00FF, 16'hFF00, 1, 1, 255);
        // mono average at the full 16x upsample, result cap reached
        add_cfg(REG_OUT_CH, 1);
        add_cfg(REG_IN_RATE, 1);
        add_cfg(REG_OUT_RATE, 16);
        add_frame(32767, 32767, 0, 0, 0);
        add_frame(-32768, -32768, 1, 1, -32768);
        // zero rate, ratio clamp, channel count 0 and 3
        add_cfg(REG_IN_RATE, 0);
        add_cfg(REG_OUT_RATE, 18'h3FFFF);
        add_cfg(REG_IN_CH, 18'h3FFFC);
        add_cfg(REG_OUT_CH, 3);
        add_frame(1000, 5, 0, 0, 0);
        add_frame(-1000, 7, 1, 1, -1000);
        // 3:1 downsample, truncation toward zero, end already given
        add_cfg(REG_IN_RATE, 3);
        add_cfg(REG_OUT_RATE, 1);
        add_cfg(REG_IN_CH, 3);
        add_cfg(REG_OUT_CH, 0);
        add_frame(-3, 0, 0, 0, 0);
        add_frame(7, 8, 0, 1, -1);
        add_frame(11, 12, 1, 0, 0);
        // rate change with a phase held mid-stream
        add_frame(5, 5, 0, 0, 0);
        add_frame(9, 9, 0, 1, 5);
        add_cfg(REG_OUT_RATE, 4);
        add_frame(21, 21, 0, 0, 0);
        add_frame(1, 1, 1, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_cfg = 0;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                if (!prev_cfg)
                    wait_idle(SETTLE_CYCLES);
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
            begin
                send_frame(dir_rows[i].a, dir_rows[i].b, dir_rows[i].fin);
                if (dir_rows[i].known && (step_results == 0 || step_last.ch0 != dir_rows[i].expv))
                    report_mismatch("hand-checked last result_first", step_last.ch0,
                                    dir_rows[i].expv);
            end
            prev_cfg = dir_rows[i].is_cfg;
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = tx_mix[ph];
            rx_stall_pct = rx_mix[ph];
            for (int grp = 0; grp < 2; grp++)
            begin
                wait_idle(SETTLE_CYCLES);
                write_reg(REG_IN_RATE, pick_rate());
                write_reg(REG_OUT_RATE, pick_rate());
                write_reg(REG_IN_CH, pick_channels());
                write_reg(REG_OUT_CH, pick_channels());
                if (ph == 2 && grp == 0)
                    hold_left = 800;            // output blocked while frames keep coming
                grp_items = 0;
                while (grp_items < GROUP_ITEMS)
                begin
                    len = $urandom_range(1, 16);
                    for (int k = 0; k < len; k++)
                    begin
                        fin = (k == len - 1);
                        // sometimes leave the stream open across the next rate change
                        if (fin && grp_items + 1 >= GROUP_ITEMS && $urandom_range(0, 1) == 0)
                            fin = 0;
                        send_frame(rand_sample(), rand_sample(), fin);
                        grp_items++;
                    end
                end
            end
        end

        wait_idle(END_SETTLE);
        $display("covered %0d items in %0d closed streams, %0d register writes,",
                 items_sent, streams_done, reg_writes);
        $display("%0d results checked across four idle/stall mixes", results_seen);
        if (error_count == 0 && pending_frames.size() == 0)
            $display("linear_interp_resampler regression: pass");
        else
            $display("linear_interp_resampler regression: fail");
        $finish;
    end

endmodule
